### hw/rtl/aocc_pkg.sv
// ----------------------------------------------------------------------------
// aocc_pkg
// Shared types and constants for the accelerometer offset calibration block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aocc_pkg;

   // log2 of the number of calibration samples averaged into one offset
   localparam int CAL_COUNT_LOG2 = 7;

   // raw axis width and running sum width (wide enough for the full count)
   localparam int AXIS_W = 16;
   localparam int SUM_W  = AXIS_W + CAL_COUNT_LOG2;

   // bias added to negative sums so that the shift truncates toward zero
   localparam logic [SUM_W-1:0] CAL_DIV_BIAS = SUM_W'((1 << CAL_COUNT_LOG2) - 1);

   // count value reached on the final calibration sample of a run
   localparam logic [CAL_COUNT_LOG2-1:0] CAL_COUNT_LAST = '1;

   // operation codes carried in the request tuser
   localparam logic OP_MEASURE   = 1'b0;
   localparam logic OP_CALIBRATE = 1'b1;

   // record tag bytes
   localparam logic [7:0] TAG_SENSOR0 = 8'h4D;  // 'M'
   localparam logic [7:0] TAG_SENSOR1 = 8'h41;  // 'A'

   // record layout
   localparam int               REC_BYTES = 7;
   localparam logic [2:0]       REC_LAST  = 3'(REC_BYTES - 1);

   // saturation limits
   localparam logic [AXIS_W-1:0] SAT_MAX = 16'h7FFF;
   localparam logic [AXIS_W-1:0] SAT_MIN = 16'h8000;

   // per-transaction control sent to each axis lane
   typedef struct packed {
      logic meas;      // measurement transaction accepted
      logic cal;       // calibration transaction accepted
      logic cal_done;  // this calibration transaction completes the run
      logic sensor;    // sensor select
   } lane_ctrl_type;

endpackage

### hw/rtl/aocc_lane.sv
// ----------------------------------------------------------------------------
// aocc_lane
// One axis lane: holds the running sums and offsets of both sensors for its
// axis, updates them on calibration and registers the corrected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aocc_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  aocc_pkg::lane_ctrl_type      ctrl,
   input  logic [aocc_pkg::AXIS_W-1:0]  value,
   output logic [aocc_pkg::AXIS_W-1:0]  corrected
);
   import aocc_pkg::*;

   logic [SUM_W-1:0]  sum_ff    [2];
   logic [AXIS_W-1:0] offset_ff [2];
   logic [AXIS_W-1:0] corr_ff;
   logic [AXIS_W-1:0] corr_in;

   logic [SUM_W-1:0]  sum_ext;
   logic [SUM_W-1:0]  sum_new;
   logic [SUM_W-1:0]  sum_biased;
   logic [AXIS_W-1:0] offset_new;
   logic [AXIS_W:0]   diff;

   // accumulate and form the average, truncating toward zero
   always_comb begin
      sum_ext    = {{CAL_COUNT_LOG2{value[AXIS_W-1]}}, value};
      sum_new    = sum_ff[ctrl.sensor] + sum_ext;
      sum_biased = sum_new + (sum_new[SUM_W-1] ? CAL_DIV_BIAS : '0);
      offset_new = sum_biased[SUM_W-1:CAL_COUNT_LOG2];
   end

   // subtract the offset and saturate to 16 bits
   always_comb begin
      diff = {value[AXIS_W-1], value}
           - {offset_ff[ctrl.sensor][AXIS_W-1], offset_ff[ctrl.sensor]};
      if (diff[AXIS_W] != diff[AXIS_W-1]) begin
         corr_in = diff[AXIS_W] ? SAT_MIN : SAT_MAX;
      end else begin
         corr_in = diff[AXIS_W-1:0];
      end
   end

   // update calibration state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
      end else if (ctrl.cal) begin
         if (ctrl.cal_done) begin
            sum_ff[ctrl.sensor]    <= '0;
            offset_ff[ctrl.sensor] <= offset_new;
         end else begin
            sum_ff[ctrl.sensor] <= sum_new;
         end
      end
   end

   // hold the corrected value for the serialiser
   always_ff @(posedge clock) begin
      if (ctrl.meas) begin
         corr_ff <= corr_in;
      end
   end

   assign corrected = corr_ff;

endmodule

### hw/rtl/aocc_serializer.sv
// ----------------------------------------------------------------------------
// aocc_serializer
// Merging stage: packs the tag and the three lane results into a 7-byte
// record and shifts it out one byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aocc_serializer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_sensor,
   input  logic [aocc_pkg::AXIS_W-1:0] in_x,
   input  logic [aocc_pkg::AXIS_W-1:0] in_y,
   input  logic [aocc_pkg::AXIS_W-1:0] in_z,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [7:0]                  out_byte,
   output logic                        out_last
);
   import aocc_pkg::*;

   logic [7:0] rec_ff [REC_BYTES];
   logic [7:0] rec_in [REC_BYTES];
   logic       busy_ff;
   logic       busy_in;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       take;
   logic       load;
   logic       is_last;

   assign is_last   = (idx_ff == REC_LAST);
   assign take      = busy_ff && out_ready;
   assign in_ready  = !busy_ff || (out_ready && is_last);
   assign load      = in_valid && in_ready;
   assign out_valid = busy_ff;
   assign out_byte  = rec_ff[0];
   assign out_last  = is_last;

   // load a new record or advance the shift line
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      for (int i = 0; i < REC_BYTES; i++) begin
         rec_in[i] = rec_ff[i];
      end
      if (load) begin
         busy_in   = 1'b1;
         idx_in    = '0;
         rec_in[0] = in_sensor ? TAG_SENSOR1 : TAG_SENSOR0;
         rec_in[1] = in_x[7:0];
         rec_in[2] = in_x[15:8];
         rec_in[3] = in_y[7:0];
         rec_in[4] = in_y[15:8];
         rec_in[5] = in_z[7:0];
         rec_in[6] = in_z[15:8];
      end else if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
            for (int i = 0; i < REC_BYTES - 1; i++) begin
               rec_in[i] = rec_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < REC_BYTES; i++) begin
         rec_ff[i] <= rec_in[i];
      end
   end

endmodule

### hw/rtl/accel_offset_calibrate_correct_core.sv
// ----------------------------------------------------------------------------
// accel_offset_calibrate_correct_core
// Offset calibration and correction for two three-axis accelerometers.
// ----------------------------------------------------------------------------
// Each request transaction carries one sample; sensor 1 samples are remapped
// (x = -y, y = -x, z = -z). A calibration sample adds to that sensor's sums
// in three axis lanes; every 128th one replaces the sensor's offsets by the
// averages. A measurement sample is corrected in the lanes in its accept
// cycle and leaves as seven response transactions, one byte per cycle while
// rsp_tready is high: tag 'M' or 'A', then x, y, z low byte first, tlast on
// the seventh. The lanes and a staging register hold the corrected values
// until the serialiser loads its record register; a new request is taken
// into the staging register while the previous record is still being sent.
`timescale 1ns / 1ps

module accel_offset_calibrate_correct_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_raw, y_raw, z_raw
   input  logic [1:0]  req_tuser,   // operation, sensor
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast
);
   import aocc_pkg::*;

   logic                      req_take;
   logic                      op;
   logic                      sensor;
   logic [AXIS_W-1:0]         x_raw;
   logic [AXIS_W-1:0]         y_raw;
   logic [AXIS_W-1:0]         z_raw;
   logic [AXIS_W-1:0]         axis_val [3];
   logic [AXIS_W-1:0]         axis_corr [3];
   lane_ctrl_type             lane_ctrl;
   logic [CAL_COUNT_LOG2-1:0] cnt_ff [2];
   logic                      stg_valid_ff;
   logic                      stg_valid_in;
   logic                      stg_sensor_ff;
   logic                      ser_ready;

   // unpack the request
   assign op       = req_tuser[0];
   assign sensor   = req_tuser[1];
   assign x_raw    = req_tdata[15:0];
   assign y_raw    = req_tdata[31:16];
   assign z_raw    = req_tdata[47:32];
   assign req_tready = !stg_valid_ff || ser_ready;
   assign req_take   = req_tvalid && req_tready;

   // remap sensor 1 axes, negation wraps in 16 bits
   always_comb begin
      if (sensor) begin
         axis_val[0] = -y_raw;
         axis_val[1] = -x_raw;
         axis_val[2] = -z_raw;
      end else begin
         axis_val[0] = x_raw;
         axis_val[1] = y_raw;
         axis_val[2] = z_raw;
      end
   end

   // lane control
   always_comb begin
      lane_ctrl.meas     = req_take && (op == OP_MEASURE);
      lane_ctrl.cal      = req_take && (op == OP_CALIBRATE);
      lane_ctrl.cal_done = (cnt_ff[sensor] == CAL_COUNT_LAST);
      lane_ctrl.sensor   = sensor;
   end

   // count calibration samples per sensor, wrapping at the end of a run
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
      end else if (lane_ctrl.cal) begin
         cnt_ff[sensor] <= cnt_ff[sensor] + 1'b1;
      end
   end

   // axis lanes
   for (genvar a = 0; a < 3; a++) begin : g_lane
      aocc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .value     (axis_val[a]),
         .corrected (axis_corr[a])
      );
   end

   // hold a corrected measurement until the serialiser takes it
   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (lane_ctrl.meas) begin
         stg_valid_in = 1'b1;
      end else if (ser_ready) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ctrl.meas) begin
         stg_sensor_ff <= sensor;
      end
   end

   // merge lane results into byte records
   aocc_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid_ff),
      .in_ready  (ser_ready),
      .in_sensor (stg_sensor_ff),
      .in_x      (axis_corr[0]),
      .in_y      (axis_corr[1]),
      .in_z      (axis_corr[2]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

### hw/rtl/aocc_chk.sv
// ----------------------------------------------------------------------------
// aocc_chk
// Port-level checks on the response record stream of the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aocc_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);
   import aocc_pkg::*;

   logic [2:0] pos_ff;

   // track the byte position within the current record
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         pos_ff <= rsp_tlast ? 3'd0 : pos_ff + 3'd1;
      end
   end

   // no response straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // tlast marks exactly the seventh byte
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (pos_ff == REC_LAST)))
      else $error("tlast out of place");

   // every record opens with a tag byte
   a_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (pos_ff == 3'd0) |-> (rsp_tdata == TAG_SENSOR0) || (rsp_tdata == TAG_SENSOR1))
      else $error("record without tag byte");

endmodule

bind accel_offset_calibrate_correct_core aocc_chk u_aocc_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
